@@ rtl/lsb_pixel_payload_codec_defines.svh @@
// Assertion macros shared by the pixel payload codec RTL.
// Included by files that check their own logic; depends on nothing else.
`ifndef LSB_PIXEL_PAYLOAD_CODEC_DEFINES_SVH
`define LSB_PIXEL_PAYLOAD_CODEC_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LSPC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lspc assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LSPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lspc assertion failed");

`endif

@@ rtl/lspc_pkg.sv @@
// Shared types and codes for the pixel payload codec.
// Used by the interfaces, the step logic and the top level.
package lspc_pkg;

  localparam int unsigned PixelWidth  = 32;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned IndexWidth  = 36;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned HeaderBits  = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CFG_MODE           = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_PAYLOAD_LENGTH = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_PIXEL_COUNT    = 2'd2;

  // Operating modes.
  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // Status codes.
  localparam logic [StatusWidth-1:0] ST_OK         = 2'd0;
  localparam logic [StatusWidth-1:0] ST_CAPACITY   = 2'd1;
  localparam logic [StatusWidth-1:0] ST_BAD_LENGTH = 2'd2;

  typedef struct packed {
    logic                  mode;
    logic [31:0]           payload_length;
    logic [31:0]           pixel_count;
  } cfg_t;

  typedef struct packed {
    logic [PixelWidth-1:0] pixel_in;
    logic [ByteWidth-1:0]  data_byte;
    logic                  image_start;
  } pix_item_t;

  typedef struct packed {
    logic [PixelWidth-1:0]  pixel_out;
    logic                   byte_valid;
    logic [ByteWidth-1:0]   byte_out;
    logic                   last_byte;
    logic [StatusWidth-1:0] status;
  } result_t;

  typedef struct packed {
    logic [IndexWidth-1:0]  bit_index;
    logic [31:0]            length_word;
    logic [ByteWidth-1:0]   byte_shift;
    logic [ByteWidth-1:0]   held_byte;
    logic [StatusWidth-1:0] error_flag;
  } state_t;

endpackage

@@ rtl/lspc_ifs.sv @@
// Valid/ready channel interfaces for pixel transactions and result transactions.
// Depends on lspc_pkg for field widths.
interface lspc_pixel_if;
  import lspc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PixelWidth-1:0] pixel_in;
  logic [ByteWidth-1:0]  data_byte;
  logic                  image_start;

  modport source (output valid, pixel_in, data_byte, image_start, input ready);
  modport sink   (input valid, pixel_in, data_byte, image_start, output ready);
endinterface

interface lspc_result_if;
  import lspc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [PixelWidth-1:0]  pixel_out;
  logic                   byte_valid;
  logic [ByteWidth-1:0]   byte_out;
  logic                   last_byte;
  logic [StatusWidth-1:0] status;

  modport source (output valid, pixel_out, byte_valid, byte_out, last_byte, status,
                  input ready);
  modport sink   (input valid, pixel_out, byte_valid, byte_out, last_byte, status,
                  output ready);
endinterface

@@ rtl/lsb_pixel_payload_codec.sv @@
// Top level of the pixel payload codec: channels, configuration registers,
// pipeline registers and codec state. Depends on lspc_pkg, lspc_ifs, lspc_step.
//
// Pixels enter as valid/ready transactions and leave one result transaction
// per pixel, in order. Sustained rate is one pixel per clock while results
// are taken without stall. A pixel is loaded into the input register at the
// edge that accepts it. Its result is loaded into the result register when
// the input stage moves on and is offered from then on. The rate is set by
// the per-pixel state update in lspc_step, which closes a loop through the
// pixel index and length registers.
// Embed mode (mode 0) places a length header and then the payload bits in
// pixel LSBs. Extract mode (mode 1) recovers the header and the payload bytes.
// Configuration writes take effect at once and are meant for idle periods,
// normally just before a transaction carrying image_start.
`include "lsb_pixel_payload_codec_defines.svh"

module lsb_pixel_payload_codec (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [lspc_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  logic [lspc_pkg::CfgDataWidth-1:0]     cfg_data,
  lspc_pixel_if.sink                            pixels,
  lspc_result_if.source                         results
);
  import lspc_pkg::*;

  cfg_t      cfg;
  pix_item_t s1_item;
  logic      s1_valid;
  logic      s1_adv;
  logic      r_valid;
  result_t   r_res;
  result_t   step_res;
  state_t    st;
  state_t    st_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:           cfg.mode           <= cfg_data[0];
        CFG_PAYLOAD_LENGTH: cfg.payload_length <= cfg_data;
        CFG_PIXEL_COUNT:    cfg.pixel_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input stage moves on when the result register is free or being taken.
  assign s1_adv       = s1_valid && (!r_valid || results.ready);
  assign pixels.ready = !s1_valid || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixels.ready) begin
      s1_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixels.valid && pixels.ready) begin
      s1_item.pixel_in    <= pixels.pixel_in;
      s1_item.data_byte   <= pixels.data_byte;
      s1_item.image_start <= pixels.image_start;
    end
  end

  // Step logic between the input register and the result register.
  lspc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (s1_item),
    .st_next (st_next),
    .res     (step_res)
  );

  // Codec state advances once per transaction that passes the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_adv) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (s1_adv) begin
      r_valid <= 1'b1;
    end else if (results.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      r_res <= step_res;
    end
  end

  assign results.valid      = r_valid;
  assign results.pixel_out  = r_res.pixel_out;
  assign results.byte_valid = r_res.byte_valid;
  assign results.byte_out   = r_res.byte_out;
  assign results.last_byte  = r_res.last_byte;
  assign results.status     = r_res.status;

  // A byte is only reported while the extracted length was good.
  `LSPC_ASSERT_NOW(a_byte_needs_ok, clk, rst, r_valid && r_res.byte_valid, r_res.status == ST_OK)
  // The last-byte mark never stands without a byte.
  `LSPC_ASSERT_NOW(a_last_has_byte, clk, rst, r_valid && r_res.last_byte, r_res.byte_valid)
  // The pixel index only moves forward unless a new image starts.
  `LSPC_ASSERT_NEXT(a_index_forward, clk, rst, s1_adv && !s1_item.image_start,
                    st.bit_index >= $past(st.bit_index))
  // The stored status is always one of the defined codes.
  `LSPC_ASSERT_NOW(a_flag_code, clk, rst, 1'b1,
                   (st.error_flag == ST_OK) || (st.error_flag == ST_CAPACITY) ||
                   (st.error_flag == ST_BAD_LENGTH))

endmodule

@@ rtl/lspc_step.sv @@
// Per-pixel step logic: from the current state, configuration and one pixel
// transaction, forms the result and the next state. Depends on lspc_pkg.
module lspc_step (
  input  lspc_pkg::cfg_t      cfg,
  input  lspc_pkg::state_t    st,
  input  lspc_pkg::pix_item_t item,
  output lspc_pkg::state_t    st_next,
  output lspc_pkg::result_t   res
);
  import lspc_pkg::*;

  state_t                cur;
  logic [2:0]            j;
  logic [32:0]           emb_len_p4;
  logic [IndexWidth-1:0] emb_total;
  logic [32:0]           ext_len_p4;
  logic [IndexWidth-1:0] ext_total;
  logic                  cap_fail;
  logic                  in_header;
  logic [ByteWidth-1:0]  emb_byte;
  logic                  emb_bit;
  logic                  ext_bit;
  logic [31:0]           lw_new;
  logic                  len_ok;
  logic [ByteWidth-1:0]  shift_new;
  logic [32:0]           last_idx;

  // A start-of-image transaction sees a cleared state.
  assign cur = item.image_start ? '0 : st;
  assign j   = cur.bit_index[2:0];

  // Stream length in pixels: header word plus payload bytes, eight pixels each.
  assign emb_len_p4 = {1'b0, cfg.payload_length} + 33'd4;
  assign emb_total  = {emb_len_p4, 3'b000};
  assign ext_len_p4 = {1'b0, cur.length_word} + 33'd4;
  assign ext_total  = {ext_len_p4, 3'b000};

  assign cap_fail  = emb_total > {4'b0000, cfg.pixel_count};
  assign in_header = cur.bit_index < IndexWidth'(HeaderBits);

  // Embed: the payload byte is sampled on the first pixel of each byte.
  assign emb_byte = (j == 3'd0) ? item.data_byte : cur.held_byte;
  assign emb_bit  = in_header ? cfg.payload_length[cur.bit_index[4:0]] : emb_byte[j];

  // Extract: gather the header, then shift payload bits into a byte.
  assign ext_bit   = item.pixel_in[0];
  assign lw_new    = cur.length_word | (32'(ext_bit) << cur.bit_index[4:0]);
  assign len_ok    = (lw_new != 32'd0) && (lw_new < cfg.pixel_count);
  assign shift_new = ((j == 3'd0) ? '0 : cur.byte_shift) | (ByteWidth'(ext_bit) << j);
  // Byte number k is last when k + 1 equals the length, i.e. index/8 == length + 3.
  assign last_idx  = {1'b0, cur.length_word} + 33'd3;

  always_comb begin
    st_next       = cur;
    res.pixel_out = item.pixel_in;
    res.byte_valid = 1'b0;
    res.byte_out  = '0;
    res.last_byte = 1'b0;
    res.status    = ST_OK;

    if (cfg.mode == MODE_EMBED) begin
      if (cap_fail) begin
        st_next.error_flag = ST_CAPACITY;
        res.status         = ST_CAPACITY;
      end else begin
        st_next.error_flag = ST_OK;
        if (in_header || (cur.bit_index < emb_total)) begin
          res.pixel_out = {item.pixel_in[PixelWidth-1:1], emb_bit};
          if (!in_header && (j == 3'd0)) begin
            st_next.held_byte = item.data_byte;
          end
        end
      end
    end else begin
      if (in_header) begin
        st_next.length_word = lw_new;
        if (cur.bit_index[4:0] == 5'd31) begin
          st_next.error_flag = len_ok ? ST_OK : ST_BAD_LENGTH;
          res.status         = len_ok ? ST_OK : ST_BAD_LENGTH;
        end
      end else begin
        res.status = cur.error_flag;
        if ((cur.error_flag == ST_OK) && (cur.bit_index < ext_total)) begin
          st_next.byte_shift = shift_new;
          if (j == 3'd7) begin
            res.byte_valid = 1'b1;
            res.byte_out   = shift_new;
            res.last_byte  = (cur.bit_index[IndexWidth-1:3] == last_idx);
          end
        end
      end
    end

    // Pixel index saturates at its all-ones value.
    if (cur.bit_index != '1) begin
      st_next.bit_index = cur.bit_index + IndexWidth'(1);
    end
  end

endmodule

@@ dv/lsb_pixel_payload_codec_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lsb_pixel_payload_codec: embed and extract images with random
// pixels and handshake gaps on both channels, each result checked against a bit-exact predictor.
// Depends on lspc_pkg, the lspc_ifs channel interfaces and the codec RTL.
module lsb_pixel_payload_codec_test;
  import lspc_pkg::*;

  localparam int unsigned RandomItems = 900;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned SettleCycles = 4;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  lspc_pixel_if  pix_ch ();
  lspc_result_if res_ch ();

  lsb_pixel_payload_codec i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_ch),
    .results   (res_ch)
  );

  // Copies of the configuration registers.
  logic        reg_mode;
  logic [31:0] reg_length;
  logic [31:0] reg_capacity;

  // Copies of the codec state.
  logic [IndexWidth-1:0]  pos_q;
  logic [31:0]            hdr_q;
  logic [ByteWidth-1:0]   assembling_q;
  logic [ByteWidth-1:0]   held_q;
  logic [StatusWidth-1:0] flag_q;

  // Predicted results, oldest first.
  result_t outcome_fifo[$];

  bit          idle_on;
  int unsigned pixels_sent;
  int unsigned images_run;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned cap_errors;
  int unsigned bad_lengths;
  int unsigned bytes_seen;
  int unsigned last_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_codec_state();
    pos_q        = '0;
    hdr_q        = '0;
    assembling_q = '0;
    held_q       = '0;
    flag_q       = ST_OK;
  endfunction

  // Works out the result of one pixel and advances the codec state.
  function automatic result_t codec_outcome(logic [31:0] pix, logic [7:0] db, logic start);
    result_t         r;
    logic [35:0]     b;
    logic [35:0]     k;
    logic [63:0]     total;
    logic [2:0]      j;
    logic            bitv;
    r           = '0;
    r.pixel_out = pix;
    r.status    = ST_OK;
    if (start) clear_codec_state();
    b = pos_q;
    if (reg_mode == MODE_EMBED) begin
      total = ({32'd0, reg_length} + 64'd4) << 3;
      if (total > {32'd0, reg_capacity}) begin
        flag_q   = ST_CAPACITY;
        r.status = ST_CAPACITY;
      end else begin
        flag_q = ST_OK;
        if (b < 36'd32) begin
          r.pixel_out = {pix[31:1], reg_length[b[4:0]]};
        end else if ({28'd0, b} < total) begin
          // The header is a whole number of bytes, so the bit position is b mod 8.
          j = b[2:0];
          if (j == 3'd0) held_q = db;
          r.pixel_out = {pix[31:1], held_q[j]};
        end
      end
    end else begin
      bitv = pix[0];
      if (b < 36'd32) begin
        hdr_q = hdr_q | ({31'd0, bitv} << b[4:0]);
        if (b == 36'd31) begin
          flag_q   = (hdr_q != 32'd0 && hdr_q < reg_capacity) ? ST_OK : ST_BAD_LENGTH;
          r.status = flag_q;
        end
      end else begin
        r.status = flag_q;
        total    = ({32'd0, hdr_q} + 64'd4) << 3;
        if (flag_q == ST_OK && {28'd0, b} < total) begin
          j = b[2:0];
          if (j == 3'd0) assembling_q = '0;
          assembling_q = assembling_q | ({7'd0, bitv} << j);
          if (j == 3'd7) begin
            k            = (b - 36'd32) >> 3;
            r.byte_valid = 1'b1;
            r.byte_out   = assembling_q;
            r.last_byte  = ((k + 36'd1) == {4'd0, hdr_q});
          end
        end
      end
    end
    if (pos_q != '1) pos_q = pos_q + 36'd1;
    return r;
  endfunction

  // Sends one pixel transaction and records its predicted result once accepted.
  task automatic send_pixel(input logic [31:0] pix, input logic [7:0] db, input logic start);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_in    <= pix;
    pix_ch.data_byte   <= db;
    pix_ch.image_start <= start;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    outcome_fifo.push_back(codec_outcome(pix, db, start));
    pixels_sent++;
  endtask

  // Lets every outstanding result come out, then waits SettleCycles further clocks with no input.
  task automatic settle_codec();
    @(negedge clk);
    pix_ch.valid       <= 1'b0;
    pix_ch.image_start <= 1'b0;
    while (outcome_fifo.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:           reg_mode     = val[0];
      CFG_PAYLOAD_LENGTH: reg_length   = val;
      CFG_PIXEL_COUNT:    reg_capacity = val;
      default: ;
    endcase
  endtask

  // The mode word carries random upper bits; only bit 0 counts.
  task automatic set_registers(input logic mode, input logic [31:0] len, input logic [31:0] cnt);
    logic [31:0] mode_word;
    settle_codec();
    mode_word    = $urandom;
    mode_word[0] = mode;
    write_reg(CFG_MODE, mode_word);
    write_reg(CFG_PAYLOAD_LENGTH, len);
    write_reg(CFG_PIXEL_COUNT, cnt);
  endtask

  // One embed image; a rare extra image start models a restart mid-stream.
  task automatic run_embed_image(input logic [31:0] len, input logic [31:0] cnt,
                                 input int unsigned npix);
    set_registers(MODE_EMBED, len, cnt);
    for (int unsigned p = 0; p < npix; p++) begin
      send_pixel($urandom, 8'($urandom), (p == 0) || ($urandom_range(0, 199) == 0));
    end
    images_run++;
  endtask

  // One extract image whose first 32 low bits spell hdr, unless noisy.
  task automatic run_extract_image(input logic [31:0] hdr, input logic [31:0] cnt,
                                   input int unsigned npix, input bit noisy);
    logic [31:0] pix;
    set_registers(MODE_EXTRACT, $urandom, cnt);
    for (int unsigned p = 0; p < npix; p++) begin
      pix = $urandom;
      if (!noisy && p < 32) pix[0] = hdr[p];
      send_pixel(pix, 8'($urandom), p == 0);
    end
    images_run++;
  endtask

  // Registers straight out of reset: zero capacity, so every pixel is a capacity error.
  task automatic test_reset_state();
    send_pixel(32'h0000_0000, 8'h00, 1'b1);
    send_pixel(32'hFFFF_FFFF, 8'hFF, 1'b0);
    send_pixel(32'h5555_5555, 8'hA5, 1'b0);
  endtask

  // Capacity check at its edges, including the largest length that still fits.
  task automatic test_capacity_edges();
    set_registers(MODE_EMBED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_pixel(32'h0000_0000, 8'h00, 1'b0);
    set_registers(MODE_EMBED, 32'd0, 32'd32);
    send_pixel(32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_pixel(32'h0000_0000, 8'h00, 1'b0);
    send_pixel(32'hAAAA_AAAB, 8'h5A, 1'b0);
    set_registers(MODE_EMBED, 32'd0, 32'd31);
    send_pixel(32'hFFFF_FFFF, 8'h00, 1'b1);
    send_pixel(32'h0000_0001, 8'hFF, 1'b0);
    set_registers(MODE_EMBED, 32'h1FFF_FFFB, 32'hFFFF_FFFF);
    send_pixel(32'h0000_0000, 8'hFF, 1'b1);
    send_pixel(32'hFFFF_FFFE, 8'h00, 1'b0);
    send_pixel(32'h1234_5678, 8'h81, 1'b0);
  endtask

  // First header pixels in extract mode report no status yet.
  task automatic test_extract_header_start();
    set_registers(MODE_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_pixel(32'h0000_0000, 8'h00, 1'b0);
    send_pixel(32'h8000_0001, 8'h7E, 1'b0);
  endtask

  // Part of an embed or extract image, then switch to the other mode without a new image start.
  task automatic test_mode_switch();
    int unsigned lead;
    int unsigned tail;
    lead = $urandom_range(8, 60);
    tail = $urandom_range(8, 40);
    if ($urandom_range(0, 1) == 0) begin
      run_embed_image($urandom_range(0, 4), $urandom_range(0, 120), lead);
      settle_codec();
      write_reg(CFG_MODE, {31'd0, MODE_EXTRACT});
    end else begin
      run_extract_image($urandom_range(0, 4), $urandom_range(0, 120), lead, 1'b0);
      settle_codec();
      write_reg(CFG_MODE, {31'd0, MODE_EMBED});
    end
    for (int unsigned p = 0; p < tail; p++) send_pixel($urandom, 8'($urandom), 1'b0);
  endtask

  task automatic random_embed();
    logic [31:0] len;
    logic [31:0] cnt;
    int unsigned total;
    len   = $urandom_range(0, 5);
    total = (len + 4) * 8;
    case ($urandom_range(0, 6))
      0:       cnt = total;
      1:       cnt = total - 1;
      2:       cnt = $urandom;
      3:       cnt = $urandom_range(0, total - 1);
      4: begin
        len = $urandom;
        cnt = $urandom;
      end
      default: cnt = total + $urandom_range(0, 16);
    endcase
    if (len > 5) run_embed_image(len, cnt, $urandom_range(4, 12));
    else run_embed_image(len, cnt, $urandom_range(total - 8, total + 8));
  endtask

  task automatic random_extract();
    logic [31:0] hdr;
    logic [31:0] cnt;
    int unsigned npix;
    hdr = $urandom_range(1, 5);
    case ($urandom_range(0, 6))
      0:       cnt = hdr + 1;
      1:       cnt = hdr;
      2: begin
        hdr = 32'd0;
        cnt = $urandom;
      end
      3: begin
        hdr = $urandom;
        cnt = 32'hFFFF_FFFF;
      end
      4: begin
        hdr = 32'hFFFF_FFFF;
        cnt = 32'hFFFF_FFFF;
      end
      default: cnt = $urandom_range(hdr + 1, 1000);
    endcase
    if (hdr == 32'd0 || hdr >= cnt) npix = 32 + $urandom_range(1, 10);
    else if (hdr > 5) npix = $urandom_range(40, 72);
    else npix = $urandom_range((hdr + 4) * 8 - 6, (hdr + 4) * 8 + 8);
    run_extract_image(hdr, cnt, npix, $urandom_range(0, 7) == 0);
  endtask

  // Mostly well-formed images with random content; some noise and mode changes.
  task automatic test_random_images();
    int unsigned stop_at;
    stop_at = pixels_sent + RandomItems;
    while (pixels_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: random_embed();
        4, 5, 6, 7: random_extract();
        default:    test_mode_switch();
      endcase
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MaxReports)
        $display("Mismatch in %s of result %0d: expected %h, got %h",
                 name, results_seen, want, got);
    end
  endfunction

  // Takes result transactions with random stalls and compares them with predictions.
  initial begin : result_checker
    result_t     want;
    int unsigned stall;
    res_ch.ready = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid === 1'b1 && rst === 1'b0));
      results_seen++;
      if (outcome_fifo.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("Result transaction with no pixel pending: pixel_out %h", res_ch.pixel_out);
      end else begin
        want = outcome_fifo.pop_front();
        check_field("pixel_out", want.pixel_out, res_ch.pixel_out);
        check_field("byte_valid", 32'(want.byte_valid), 32'(res_ch.byte_valid));
        check_field("byte_out", 32'(want.byte_out), 32'(res_ch.byte_out));
        check_field("last_byte", 32'(want.last_byte), 32'(res_ch.last_byte));
        check_field("status", 32'(want.status), 32'(res_ch.status));
        if (want.status == ST_CAPACITY) cap_errors++;
        if (want.status == ST_BAD_LENGTH) bad_lengths++;
        if (want.byte_valid) bytes_seen++;
        if (want.last_byte) last_seen++;
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = CFG_MODE;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel_in    = '0;
    pix_ch.data_byte   = '0;
    pix_ch.image_start = 1'b0;
    reg_mode           = MODE_EMBED;
    reg_length         = '0;
    reg_capacity       = '0;
    clear_codec_state();
    idle_on            = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_capacity_edges();
    test_extract_header_start();
    test_random_images();
    settle_codec();

    $display("Checked %0d results from %0d pixels over %0d images.",
             results_seen, pixels_sent, images_run);
    $display("Capacity errors %0d, bad lengths %0d, bytes extracted %0d, final bytes %0d.",
             cap_errors, bad_lengths, bytes_seen, last_seen);
    if (fail_count == 0 && outcome_fifo.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (outcome_fifo.size() != 0)
        $display("%0d predicted results never arrived.", outcome_fifo.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lspc_pkg.sv
rtl/lspc_ifs.sv
rtl/lspc_step.sv
rtl/lsb_pixel_payload_codec.sv
dv/lsb_pixel_payload_codec_test.sv
